[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[rtl/core/bte_pkg.sv]
// Types and constants of the bond table editor
`timescale 1ns / 1ps
package bte_pkg;
  localparam logic [1:0] OP_ADD_ATOM = 2'd0;
  localparam logic [1:0] OP_ADD_BOND = 2'd1;
  localparam logic [1:0] OP_DROP     = 2'd2;
  localparam logic [1:0] OP_VALENCE  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_NOSLOT  = 3'd3;
  localparam logic [2:0] ST_VALENCE = 3'd4;

  localparam logic [3:0] KIND_H  = 4'd2;
  localparam logic [3:0] KIND_F  = 4'd5;
  localparam logic [3:0] KIND_P  = 4'd6;
  localparam logic [3:0] KIND_CL = 4'd8;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] atom_kind;
    logic [7:0] first_atom;
    logic [7:0] second_atom;
    logic [1:0] bond_order;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] atom_total;
    logic [7:0] bad_atom;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_BOND_RD, S_BOND_EV, S_BOND_WB, S_BOND_WA,
    S_MOVE_RD, S_MOVE_WR, S_FIX_RD, S_FIX_WR, S_VAL_RD, S_VAL_EV, S_DONE
  } state_t;

  // valence rule check on one summed atom
  function automatic logic rule_broken(input logic [3:0] kind, input logic [4:0] sum);
    logic hal;
    begin
      hal = (kind == KIND_H) || (kind == KIND_F) || (kind == KIND_CL);
      return (hal && sum != 5'd1) || (kind == KIND_P && sum != 5'd3);
    end
  endfunction
endpackage

[rtl/core/bte_stream_if.sv]
// Valid/ready channel carrying a payload
`timescale 1ns / 1ps
interface bte_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/bte_ram.sv]
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module bte_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/core/bond_table_editor_top.sv]
// Top level of the bond table editor
`timescale 1ns / 1ps
// Bond table editor: keeps a small atom graph, one row per atom holding the
// element kind and SLOTS_PER_ATOM neighbour slots (used bit, index, order).
// Channels: req (sink) takes op, atom_kind, first_atom, second_atom,
// bond_order; rsp (source) gives status, atom_total, bad_atom. One response
// per request. The row lives in one RAM (one read or write per cycle) and a
// small sequencer walks it, in these steps from accept to rsp.valid:
//   add atom: writes the new row (not when full); add bond: reads the
//   first and second rows, then writes the link into each that needs it;
//   drop atom: a move pass copies each row above the dropped one down,
//   then a fix pass rewrites every remaining row;
//   valence check: reads and checks each atom in turn, stopping at the
//   first bad atom. A bad index or an empty table skips the RAM walk.
// req.ready is high only in the idle state; one request is in flight. After
// the response is taken the block returns to idle and takes the next request.
// The response is held in a register until taken; a stalled receiver holds
// the block, which takes no new request until the response is gone.
// Reset (synchronous) clears the atom count and sequencer; the RAM needs no
// clearing since rows at or above the count are never read.
`include "assert_macros.svh"
module bond_table_editor_top
  import bte_pkg::*;
#(
  parameter int MAX_ATOMS      = 256,
  parameter int SLOTS_PER_ATOM = 4
) (
  input logic clk,
  input logic rst,
  bte_stream_if.sink   req,
  bte_stream_if.source rsp
);
  localparam int AW  = $clog2(MAX_ATOMS);
  localparam int CW  = $clog2(MAX_ATOMS + 1);
  localparam int IW  = (CW > 8) ? CW : 8;         // index compare width
  localparam int SL  = SLOTS_PER_ATOM;
  localparam int SW  = 1 + CW + 2;                // used, index, order
  localparam int RW  = 4 + SL * SW;
  localparam int JW  = $clog2(SL + 1);

  typedef struct packed {
    logic          used;
    logic [CW-1:0] nb;
    logic [1:0]    ord;
  } slot_t;
  typedef struct packed {
    logic [3:0]     kind;
    slot_t [SL-1:0] slots;
  } row_t;

  state_t state, state_next;
  req_t   cur;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;       // row walk pointer
  row_t   row_a, wrow;      // latched row of first atom / write data
  logic   need_a, need_b;
  logic   row_b_free, row_a_free;
  logic   bond_ok;
  rsp_t   res;
  logic   rsp_valid;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [RW-1:0] ram_rdata;
  row_t          rd;

  bte_ram #(.Width(RW), .Depth(MAX_ATOMS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wrow), .rdata(ram_rdata)
  );
  assign rd = row_t'(ram_rdata);

  logic [IW-1:0] a_ix, b_ix, cnt_ix;
  assign a_ix   = IW'(cur.first_atom);
  assign b_ix   = IW'(cur.second_atom);
  assign cnt_ix = IW'(count);

  // bond can be placed in every direction that needs it
  assign bond_ok = !((need_a && !row_a_free) || (need_b && !row_b_free));

  // slot helpers on the current read row
  function automatic logic has_link(input row_t r, input logic [CW-1:0] t);
    logic f;
    begin
      f = 1'b0;
      for (int j = 0; j < SL; j++) if (r.slots[j].used && r.slots[j].nb == t) f = 1'b1;
      return f;
    end
  endfunction
  function automatic logic has_free(input row_t r);
    logic f;
    begin
      f = 1'b0;
      for (int j = 0; j < SL; j++) if (!r.slots[j].used) f = 1'b1;
      return f;
    end
  endfunction
  function automatic row_t put_link(input row_t r, input logic [CW-1:0] t,
                                    input logic [1:0] o);
    row_t q;
    logic done;
    begin
      q = r;
      done = 1'b0;
      for (int j = 0; j < SL; j++) begin
        if (!done && !q.slots[j].used) begin
          q.slots[j].used = 1'b1;
          q.slots[j].nb   = t;
          q.slots[j].ord  = o;
          done = 1'b1;
        end
      end
      return q;
    end
  endfunction
  // drop links to n, renumber above n, compact used slots first
  function automatic row_t fix_row(input row_t r, input logic [CW-1:0] n);
    row_t q;
    slot_t s;
    logic [JW-1:0] k;
    begin
      q = r;
      k = '0;
      for (int j = 0; j < SL; j++) q.slots[j] = '0;
      for (int j = 0; j < SL; j++) begin
        s = r.slots[j];
        if (s.used && s.nb != n) begin
          if (s.nb > n) s.nb = s.nb - CW'(1);
          q.slots[k[$clog2(SL > 1 ? SL : 2)-1:0]] = s;
          k = k + JW'(1);
        end
      end
      return q;
    end
  endfunction
  function automatic logic [4:0] ord_sum(input row_t r);
    logic [4:0] s;
    begin
      s = '0;
      for (int j = 0; j < SL; j++) if (r.slots[j].used) s = s + 5'(r.slots[j].ord);
      return s;
    end
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (req.valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (cur.op)
          OP_ADD_ATOM: state_next = S_DONE;
          OP_ADD_BOND: state_next = (a_ix >= cnt_ix || b_ix >= cnt_ix) ? S_DONE : S_BOND_RD;
          OP_DROP:     state_next = (a_ix >= cnt_ix) ? S_DONE :
                                    (idx + CW'(1) < count) ? S_MOVE_RD : S_FIX_RD;
          default:     state_next = (count == '0) ? S_DONE : S_VAL_RD;
        endcase
      end
      S_BOND_RD:  state_next = S_BOND_EV;
      S_BOND_EV:  state_next = S_BOND_WB;
      S_BOND_WB:  state_next = S_BOND_WA;
      S_BOND_WA:  state_next = S_DONE;
      S_MOVE_RD:  state_next = S_MOVE_WR;
      // count already holds the count after the drop here
      S_MOVE_WR:  state_next = (idx + CW'(1) < count) ? S_MOVE_RD : S_FIX_RD;
      S_FIX_RD:   state_next = (idx >= count) ? S_DONE : S_FIX_WR;
      S_FIX_WR:   state_next = (idx + CW'(1) < count) ? S_FIX_RD : S_DONE;
      S_VAL_RD:   state_next = S_VAL_EV;
      S_VAL_EV:   state_next = (rule_broken(rd.kind, ord_sum(rd)) || idx + CW'(1) >= count)
                               ? S_DONE : S_VAL_RD;
      S_DONE:     if (!rsp_valid) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = AW'(idx);
    wrow     = rd;
    unique case (state)
      S_DISPATCH: begin
        if (cur.op == OP_ADD_ATOM && count < CW'(MAX_ATOMS)) begin
          ram_we   = 1'b1;
          ram_addr = AW'(count);
          wrow     = '0;
          wrow.kind = cur.atom_kind;
        end else if (cur.op == OP_ADD_BOND) begin
          ram_addr = AW'(a_ix);
        end else if (cur.op == OP_DROP) begin
          ram_addr = AW'(a_ix + IW'(1));
        end else begin
          ram_addr = '0;
        end
      end
      S_BOND_RD:  ram_addr = AW'(b_ix);
      S_BOND_EV:  ram_addr = AW'(b_ix);
      S_BOND_WB: begin
        ram_addr = AW'(b_ix);
        wrow     = put_link(rd, CW'(a_ix), cur.bond_order);
        ram_we   = need_b && bond_ok;
      end
      S_BOND_WA: begin
        ram_addr = AW'(a_ix);
        wrow     = put_link(row_a, CW'(b_ix), cur.bond_order);
        ram_we   = need_a && bond_ok;
      end
      S_MOVE_RD:  ram_addr = AW'(idx + CW'(1));
      S_MOVE_WR: begin
        ram_addr = AW'(idx);
        ram_we   = 1'b1;
      end
      S_FIX_RD:   ram_addr = AW'(idx);
      S_FIX_WR: begin
        ram_addr = AW'(idx);
        wrow     = fix_row(rd, CW'(a_ix));
        ram_we   = 1'b1;
      end
      S_VAL_RD:   ram_addr = AW'(idx);
      default:    ram_addr = AW'(idx);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid) begin
          cur <= req.data;
          idx <= (req.data.op == OP_VALENCE) ? '0 : CW'(req.data.first_atom);
        end
        S_DISPATCH: begin
          res.bad_atom <= '0;
          unique case (cur.op)
            OP_ADD_ATOM: begin
              if (count >= CW'(MAX_ATOMS)) begin
                res.status     <= ST_FULL;
                res.atom_total <= 9'(count);
              end else begin
                res.status     <= ST_OK;
                count          <= count + CW'(1);
                res.atom_total <= 9'(count + CW'(1));
              end
            end
            OP_ADD_BOND: begin
              res.atom_total <= 9'(count);
              res.status     <= (a_ix >= cnt_ix || b_ix >= cnt_ix) ? ST_RANGE : ST_OK;
            end
            OP_DROP: begin
              if (a_ix >= cnt_ix) begin
                res.status     <= ST_RANGE;
                res.atom_total <= 9'(count);
              end else begin
                res.status     <= ST_OK;
                count          <= count - CW'(1);
                res.atom_total <= 9'(count - CW'(1));
                if (!(idx + CW'(1) < count)) idx <= '0;
              end
            end
            default: begin
              res.status     <= ST_OK;
              res.atom_total <= 9'(count);
            end
          endcase
        end
        S_BOND_RD: begin
          row_a      <= rd;
          row_a_free <= has_free(rd);
          need_a     <= !has_link(rd, CW'(b_ix));
        end
        S_BOND_EV: begin
          row_b_free <= has_free(rd);
          need_b     <= (a_ix != b_ix) && !has_link(rd, CW'(a_ix));
        end
        S_BOND_WB: ;
        S_BOND_WA: if (!bond_ok) res.status <= ST_NOSLOT;
        S_MOVE_WR: idx <= (idx + CW'(1) < count) ? idx + CW'(1) : '0;
        S_FIX_RD: ;
        S_FIX_WR: idx <= idx + CW'(1);
        S_VAL_EV: begin
          if (rule_broken(rd.kind, ord_sum(rd))) begin
            res.status   <= ST_VALENCE;
            res.bad_atom <= 8'(idx);
          end
          idx <= idx + CW'(1);
        end
        S_DONE: ;
        default: ;
      endcase
      if (state_next == S_DONE && state != S_DONE) rsp_valid <= 1'b1;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = res;

  `ASSERT_IMPLIES(a_count_max, clk, rst, 1'b1, count <= CW'(MAX_ATOMS))
  `ASSERT_IMPLIES(a_busy_rsp, clk, rst, rsp_valid, state == S_DONE)
  `ASSERT_NEXT(a_take, clk, rst, req.valid && req.ready, state == S_DISPATCH)
endmodule
